// ===== design/asl_pkg.sv =====
// Shared types and constants for the lookahead scanner.
// Holds the command codes, scan state enums, verdict codes and the
// structs that pass between the control and word units. No dependencies.
package asl_pkg;

   // Command codes carried in the request tuser bit.
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_CHAR  = 1'b1;

   // Widths of a result verdict, the result tdata bus, a code point and the request tdata bus.
   localparam int VERDICT_W  = 2;
   localparam int RSP_DATA_W = 8;
   localparam int CODE_W     = 21;
   localparam int REQ_DATA_W = 24;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_STMT   = 2'd1,
      MODE_MEMBER = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PHASE_PLAIN = 2'd0,
      PHASE_SLASH = 2'd1,
      PHASE_LINE  = 2'd2,
      PHASE_BLOCK = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      TAIL_NONE  = 2'd0,
      TAIL_SIGN  = 2'd1,
      TAIL_SWORD = 2'd2,
      TAIL_MWORD = 2'd3
   } tail_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_NONE       = 2'd0,
      VERDICT_SEMICOLON  = 2'd1,
      VERDICT_MEMBER_END = 2'd2
   } verdict_type;

   // Request from the control unit to the word collector.
   typedef struct packed {
      logic       clear;   // start of a new scan, empty the word
      logic       en;      // this character belongs to a word
      logic       fresh;   // first letter of a new word
      logic       member;  // member word limit applies
      logic       lower;   // character is a lowercase letter
      logic [4:0] letter;  // letter index, a is zero
   } word_req_type;

   // Status from the word collector, valid in the same cycle as the request.
   typedef struct packed {
      logic stored;          // the letter was added to the word
      logic member_pending;  // member word still open after this letter
      logic stmt_hit;        // word is one of the statement keywords
      logic ext_hit;         // word is extends
   } word_stat_type;

endpackage

// ===== design/asi_lookahead_scanner.sv =====
// Top level of the lookahead scanner: input register, scan control, word
// collector and result register. Depends on asl_pkg, asl_ctrl and asl_word.
//
// Decides automatic semicolon insertion and type member ends from a stream
// of lookahead code points. A start transaction (tuser 0) latches the two
// grammar flags; character transactions (tuser 1) follow, code point 0 being
// end of input. Each scan gives one result, when the decision falls, and
// ignores further characters until the next start. The block takes one
// transaction per cycle: each item is processed in a single pass through the
// scan state logic between the input register and the result register,
// and the input stalls only while a result waits in the result register.
module asi_lookahead_scanner #(
   parameter int WORD_LIMIT        = 10,
   parameter int MEMBER_WORD_LIMIT = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: asi_allowed [0], member_end_allowed [1], char_code [22:2], zero [23]
   input  logic [asl_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: command [0]
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: verdict [1:0], zero [7:2]
   output logic [asl_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import asl_pkg::*;

   logic                 in_valid_ff, in_valid_in;
   logic                 in_cmd_ff;
   logic                 in_asi_ff;
   logic                 in_mem_ff;
   logic [CODE_W-1:0]    in_code_ff;
   logic                 step_fire;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] rsp_verdict_ff;
   word_req_type         wreq;
   word_stat_type        wstat;
   logic                 res_valid;
   verdict_type          res_verdict;

   // The held item is processed when the result register can take a result.
   assign step_fire  = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step_fire;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign rsp_valid_in = step_fire ? res_valid : (rsp_valid_ff && !rsp_tready);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_asi_ff  <= req_tdata[0];
         in_mem_ff  <= req_tdata[1];
         in_code_ff <= req_tdata[CODE_W+1:2];
      end
   end

   asl_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .fire               (step_fire),
      .cmd                (in_cmd_ff),
      .asi_allowed        (in_asi_ff),
      .member_end_allowed (in_mem_ff),
      .char_code          (in_code_ff),
      .wstat              (wstat),
      .wreq               (wreq),
      .res_valid          (res_valid),
      .res_verdict        (res_verdict)
   );

   asl_word #(
      .WORD_LIMIT        (WORD_LIMIT),
      .MEMBER_WORD_LIMIT (MEMBER_WORD_LIMIT)
   ) u_word (
      .clock (clock),
      .reset (reset),
      .req   (wreq),
      .stat  (wstat)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire && res_valid) begin
         rsp_verdict_ff <= res_verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VERDICT_W)'(0), rsp_verdict_ff};

`ifndef SYNTHESIS
   a_hold_blocked_item : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !step_fire) |=> (in_valid_ff && $stable(in_code_ff)
                                       && $stable(in_cmd_ff)))
      else $error("blocked input item was lost or changed");
`endif

`ifndef SYNTHESIS
   a_ready_only_when_free : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked result");
`endif

endmodule

// ===== design/asl_word.sv =====
// Word collector for the lookahead scanner: letter registers, length count
// and the fixed keyword compares. Depends on asl_pkg.
module asl_word #(
   parameter int WORD_LIMIT        = 10,
   parameter int MEMBER_WORD_LIMIT = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  asl_pkg::word_req_type req,
   output asl_pkg::word_stat_type stat
);
   import asl_pkg::*;

   localparam int LETTER_DEPTH = (WORD_LIMIT > MEMBER_WORD_LIMIT) ? WORD_LIMIT
                                                                  : MEMBER_WORD_LIMIT;
   localparam int COUNT_W  = $clog2(LETTER_DEPTH + 1);
   localparam int IDX_W    = $clog2(LETTER_DEPTH);
   localparam int WORD_MAX = 10;

   logic [4:0]         letters_ff [LETTER_DEPTH];
   logic [4:0]         letters_in [LETTER_DEPTH];
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic [COUNT_W-1:0] base;
   logic [COUNT_W-1:0] limit;
   logic               stored;

   // Compares the word as it stands after this letter against a keyword.
   // The keyword is packed with its first character in the highest byte used.
   function automatic logic word_is(input logic [4:0] l [LETTER_DEPTH],
                                    input logic [COUNT_W-1:0] cnt,
                                    input logic [WORD_MAX*8-1:0] w,
                                    input int len);
      logic hit;
      int   pos;
      hit = (cnt == COUNT_W'(len));
      for (int i = 0; i < WORD_MAX; i++) begin
         if (i < len) begin
            pos = (len - 1 - i) * 8;
            if (l[i] != 5'(w[pos +: 8] - 8'h61)) begin
               hit = 1'b0;
            end
         end
      end
      return hit;
   endfunction

   // Append a lowercase letter while the word is below its limit.
   always_comb begin
      base   = req.fresh ? '0 : count_ff;
      limit  = req.member ? COUNT_W'(MEMBER_WORD_LIMIT) : COUNT_W'(WORD_LIMIT);
      stored = req.lower && (base < limit);
      letters_in = letters_ff;
      count_in   = base;
      if (stored) begin
         letters_in[base[IDX_W-1:0]] = req.letter;
         count_in = base + COUNT_W'(1);
      end
   end

   // Keyword compares on the updated word.
   always_comb begin
      stat.stored         = stored;
      stat.member_pending = stored && (count_in < COUNT_W'(MEMBER_WORD_LIMIT));
      stat.stmt_hit       = word_is(letters_in, count_in, 80'("in"), 2)
                         || word_is(letters_in, count_in, 80'("instanceof"), 10)
                         || word_is(letters_in, count_in, 80'("as"), 2)
                         || word_is(letters_in, count_in, 80'("satisfies"), 9)
                         || word_is(letters_in, count_in, 80'("extends"), 7);
      stat.ext_hit        = word_is(letters_in, count_in, 80'("extends"), 7);
   end

   // Word length count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (req.clear) begin
         count_ff <= '0;
      end else if (req.en) begin
         count_ff <= count_in;
      end
   end

   // Letter storage, no reset needed.
   always_ff @(posedge clock) begin
      if (req.en && !req.clear) begin
         letters_ff <= letters_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(LETTER_DEPTH))
      else $error("word count beyond letter storage");
`endif

endmodule

// ===== design/asl_ctrl.sv =====
// Scan control for the lookahead scanner: trivia state, break tracking,
// sign and word tails and the single decision per scan. Depends on asl_pkg
// and works with the word collector asl_word.
module asl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  logic                   cmd,
   input  logic                   asi_allowed,
   input  logic                   member_end_allowed,
   input  logic [20:0]            char_code,
   input  asl_pkg::word_stat_type wstat,
   output asl_pkg::word_req_type  wreq,
   output logic                   res_valid,
   output asl_pkg::verdict_type   res_verdict
);
   import asl_pkg::*;

   typedef struct packed {
      logic blank;
      logic brk;
      logic eof;
      logic slash;
      logic star;
      logic close_brace;
      logic plus;
      logic minus;
      logic lower;
      logic ident;
      logic stmt_punct;
      logic member_punct;
      logic word_start;
      logic e_char;
   } char_class_type;

   // Character classes used by the scan.
   function automatic char_class_type classify(input logic [20:0] c);
      char_class_type k;
      k.blank        = c inside {21'h20, 21'h09, 21'h0C, 21'h0B};
      k.brk          = c inside {21'h0A, 21'h0D, 21'h2028, 21'h2029};
      k.eof          = (c == 21'h0);
      k.slash        = (c == 21'h2F);
      k.star         = (c == 21'h2A);
      k.close_brace  = (c == 21'h7D);
      k.plus         = (c == 21'h2B);
      k.minus        = (c == 21'h2D);
      k.lower        = c inside {[21'h61:21'h7A]};
      k.ident        = c inside {21'h5F, 21'h24, [21'h61:21'h7A], [21'h41:21'h5A],
                                 [21'h30:21'h39]};
      // ( [ ` * % < > = & | ^ ? : , . ; !
      k.stmt_punct   = c inside {21'h28, 21'h5B, 21'h60, 21'h2A, 21'h25, 21'h3C, 21'h3E,
                                 21'h3D, 21'h26, 21'h7C, 21'h5E, 21'h3F, 21'h3A, 21'h2C,
                                 21'h2E, 21'h3B, 21'h21};
      // ( ` * % < > = & | ^ ? : , . ; ! - + /
      k.member_punct = c inside {21'h28, 21'h60, 21'h2A, 21'h25, 21'h3C, 21'h3E, 21'h3D,
                                 21'h26, 21'h7C, 21'h5E, 21'h3F, 21'h3A, 21'h2C, 21'h2E,
                                 21'h3B, 21'h21, 21'h2D, 21'h2B, 21'h2F};
      // i a s e open the statement keywords
      k.word_start   = c inside {21'h69, 21'h61, 21'h73, 21'h65};
      k.e_char       = (c == 21'h65);
      return k;
   endfunction

   mode_type  mode_ff,  mode_in;
   phase_type phase_ff, phase_in;
   tail_type  tail_ff,  tail_in;
   logic      star_ff,  star_in;
   logic      brk_ff,   brk_in;
   logic      sign_ff,  sign_in;

   // Next scan state and the decision for one processed transaction.
   always_comb begin
      char_class_type cls;
      logic           go_ws;
      logic           tok;
      logic           sword;
      logic           mword;
      logic           decide;
      verdict_type    verdict;

      cls      = classify(char_code);
      go_ws    = 1'b0;
      tok      = 1'b0;
      sword    = 1'b0;
      mword    = 1'b0;
      decide   = 1'b0;
      verdict  = VERDICT_NONE;
      mode_in  = mode_ff;
      phase_in = phase_ff;
      tail_in  = tail_ff;
      star_in  = star_ff;
      brk_in   = brk_ff;
      sign_in  = sign_ff;
      wreq     = '0;
      wreq.lower  = cls.lower;
      wreq.letter = 5'(char_code[4:0] - 5'd1);
      res_valid   = 1'b0;
      res_verdict = VERDICT_NONE;

      if (fire) begin
         if (cmd == CMD_START) begin
            // Open a new scan; with no flag the scan declines at once.
            phase_in   = PHASE_PLAIN;
            star_in    = 1'b0;
            brk_in     = 1'b0;
            tail_in    = TAIL_NONE;
            sign_in    = 1'b0;
            wreq.clear = 1'b1;
            if (asi_allowed) begin
               mode_in = MODE_STMT;
            end else if (member_end_allowed) begin
               mode_in = MODE_MEMBER;
            end else begin
               mode_in     = MODE_IDLE;
               res_valid   = 1'b1;
               res_verdict = VERDICT_NONE;
            end
         end else if (mode_ff != MODE_IDLE) begin
            case (tail_ff)
               TAIL_SIGN: begin
                  decide  = 1'b1;
                  verdict = (sign_ff ? cls.minus : cls.plus) ? VERDICT_SEMICOLON
                                                             : VERDICT_NONE;
               end
               TAIL_SWORD: begin
                  sword = 1'b1;
               end
               TAIL_MWORD: begin
                  mword = 1'b1;
               end
               TAIL_NONE: begin
                  // Skip comments first, then blanks and breaks.
                  case (phase_ff)
                     PHASE_SLASH: begin
                        if (cls.slash) begin
                           phase_in = PHASE_LINE;
                        end else if (cls.star) begin
                           phase_in = PHASE_BLOCK;
                           star_in  = 1'b0;
                        end else begin
                           decide  = 1'b1;
                           verdict = VERDICT_NONE;
                        end
                     end
                     PHASE_LINE: begin
                        if (cls.eof || cls.brk) begin
                           phase_in = PHASE_PLAIN;
                           go_ws    = 1'b1;
                        end
                     end
                     PHASE_BLOCK: begin
                        if (!cls.eof) begin
                           if (cls.brk) begin
                              brk_in = 1'b1;
                           end
                           if (star_ff && cls.slash) begin
                              phase_in = PHASE_PLAIN;
                           end else begin
                              star_in = cls.star;
                           end
                        end else begin
                           phase_in = PHASE_PLAIN;
                           go_ws    = 1'b1;
                        end
                     end
                     PHASE_PLAIN: begin
                        go_ws = 1'b1;
                     end
                     default: ;
                  endcase

                  if (go_ws) begin
                     if (cls.brk) begin
                        brk_in = 1'b1;
                     end else if (cls.slash) begin
                        phase_in = PHASE_SLASH;
                     end else if (!cls.blank) begin
                        tok = 1'b1;
                     end
                  end
               end
               default: ;
            endcase

            // First significant character after the trivia.
            if (tok) begin
               if (mode_ff == MODE_MEMBER) begin
                  if (!brk_ff || cls.member_punct) begin
                     decide  = 1'b1;
                     verdict = VERDICT_NONE;
                  end else if (cls.e_char) begin
                     tail_in    = TAIL_MWORD;
                     wreq.fresh = 1'b1;
                     mword      = 1'b1;
                  end else begin
                     decide  = 1'b1;
                     verdict = VERDICT_MEMBER_END;
                  end
               end else begin
                  if (cls.eof || cls.close_brace) begin
                     decide  = 1'b1;
                     verdict = VERDICT_SEMICOLON;
                  end else if (!brk_ff) begin
                     decide  = 1'b1;
                     verdict = VERDICT_NONE;
                  end else if (cls.plus || cls.minus) begin
                     tail_in = TAIL_SIGN;
                     sign_in = cls.minus;
                  end else if (cls.stmt_punct) begin
                     decide  = 1'b1;
                     verdict = VERDICT_NONE;
                  end else if (cls.word_start) begin
                     tail_in    = TAIL_SWORD;
                     wreq.fresh = 1'b1;
                     sword      = 1'b1;
                  end else begin
                     decide  = 1'b1;
                     verdict = VERDICT_SEMICOLON;
                  end
               end
            end

            // Statement word: decide once the word has ended.
            if (sword) begin
               wreq.en     = 1'b1;
               wreq.member = 1'b0;
               if (!wstat.stored) begin
                  decide  = 1'b1;
                  verdict = (!cls.ident && wstat.stmt_hit) ? VERDICT_NONE
                                                           : VERDICT_SEMICOLON;
               end
            end

            // Member word: decide at a non-letter or at the length limit.
            if (mword) begin
               wreq.en     = 1'b1;
               wreq.member = 1'b1;
               if (!wstat.member_pending) begin
                  decide  = 1'b1;
                  verdict = wstat.ext_hit ? VERDICT_NONE : VERDICT_MEMBER_END;
               end
            end

            if (decide) begin
               mode_in     = MODE_IDLE;
               res_valid   = 1'b1;
               res_verdict = verdict;
            end
         end
      end
   end

   // Scan state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         phase_ff <= PHASE_PLAIN;
         tail_ff  <= TAIL_NONE;
         star_ff  <= 1'b0;
         brk_ff   <= 1'b0;
         sign_ff  <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         tail_ff  <= tail_in;
         star_ff  <= star_in;
         brk_ff   <= brk_in;
         sign_ff  <= sign_in;
      end
   end

`ifndef SYNTHESIS
   a_idle_after_decision : assert property (@(posedge clock) disable iff (reset)
      (fire && (cmd == CMD_CHAR) && res_valid) |=> (mode_ff == MODE_IDLE))
      else $error("scan still open after its decision");
`endif

endmodule
